// ===== hw/rtl/rmpm_pkg.sv =====
// Shared constants and types for the 3x3 recurrence matrix power block.
// Holds the modulus, the reduction constant and the fixed base matrix.
// No dependencies.
`default_nettype none

package rmpm_pkg;

  localparam int unsigned EXP_BITS = 62;
  localparam int unsigned CNT_W    = $clog2(EXP_BITS + 1);

  localparam int unsigned VAL_W  = 27;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned MU_W   = 28;
  localparam int unsigned RES_W  = 29;

  localparam logic [63:0] MOD_WIDE = 64'd98765431;
  localparam logic [63:0] MU_WIDE  = (64'd1 << PROD_W) / MOD_WIDE;
  localparam logic [63:0] MOD2_WIDE = MOD_WIDE * 64'd2;

  localparam logic [VAL_W-1:0] MODULUS    = MOD_WIDE[VAL_W-1:0];
  localparam logic [RES_W-1:0] MODULUS_X1 = MOD_WIDE[RES_W-1:0];
  localparam logic [RES_W-1:0] MODULUS_X2 = MOD2_WIDE[RES_W-1:0];
  localparam logic [MU_W-1:0]  MU         = MU_WIDE[MU_W-1:0];

  typedef logic [1:0] idx_t;
  localparam idx_t IDX_FIRST = 2'd0;
  localparam idx_t IDX_LAST  = 2'd2;

  // Tag carried alongside each product through the multiply pipeline.
  typedef struct packed {
    logic vld;
    idx_t i;
    idx_t j;
    idx_t k;
  } tag_t;

  // Base matrix [[1,1,1],[1,0,1],[1,1,0]].
  function automatic logic [VAL_W-1:0] base_entry(idx_t r, idx_t c);
    logic zero;
    zero = (r == 2'd1 && c == 2'd1) || (r == 2'd2 && c == 2'd2);
    return zero ? '0 : VAL_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/recurrence_matrix_power_mod.sv =====
// Top level: 3x3 matrix power modulo 98765431, top-left entry of the result.
// Running matrix lives in a two-bank synchronous RAM; one pipelined modular MAC.
// Depends on rmpm_pkg.
//
// Usage:
//   Input channel: exponent_i with in_valid_i / in_stall_o. A transaction is
//   taken only while the block is idle; in_stall_o stays high for the whole
//   computation. Output channel: top_left_o with out_valid_o / out_stall_i,
//   one result per input transaction, held in an output register.
//   The scan visits all EXP_BITS exponent bits. Each bit below the top set bit
//   costs a squaring, plus a multiply by the base matrix if that bit is set.
//   Each squaring and each multiply is a pass of 27 products issued one per
//   cycle into the multiply/Barrett pipeline, which then drains before the
//   banks swap. The shared MAC pipeline and the single write port of the
//   matrix RAM bound the run time.
//   Reset clears all control state; the RAM needs no clearing, since the
//   base matrix is supplied from constants until the first pass writes it.
//   If the receiver stalls, the result waits in the output register, and a
//   finished computation waits for that register before returning to idle.
`default_nettype none

module recurrence_matrix_power_mod import rmpm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [EXP_BITS-1:0] exponent_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [VAL_W-1:0]         top_left_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_ISSUE  = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_READ   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  typedef logic [4:0] addr_t;

  state_e               state_q, state_d;
  logic [EXP_BITS-1:0]  exp_q, exp_d;
  logic [CNT_W-1:0]     bits_left_q, bits_left_d;
  logic                 started_q, started_d;
  logic                 cur_bit_q, cur_bit_d;
  logic                 mul_base_q, mul_base_d;
  logic                 base_q, base_d;
  logic                 cur_bank_q, cur_bank_d;
  idx_t                 i_q, i_d, j_q, j_d, k_q, k_d;
  logic                 out_valid_q, out_valid_d;
  logic [VAL_W-1:0]     top_left_q, top_left_d;

  // Matrix RAM: two banks of 3x3 entries.
  logic [VAL_W-1:0]     mat_mem [32];
  logic [VAL_W-1:0]     rd_a_q, rd_b_q;
  addr_t                rd_a_addr, rd_b_addr, wr_addr;
  logic                 wr_en;
  logic [VAL_W-1:0]     wr_data;

  // MAC pipeline.
  tag_t                 tag0, tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  logic [VAL_W-1:0]     op_a, op_b;
  logic [PROD_W-1:0]    prod_d, prod_q;
  logic [2*MU_W-1:0]    q2_d, q2_q;
  logic [RES_W-1:0]     p2_q, p3_q;
  logic [MU_W+VAL_W-1:0] q3m_full;
  logic [RES_W-1:0]     q3m_q;
  logic [RES_W-1:0]     rem_raw;
  logic [VAL_W-1:0]     res_d, res_q;
  logic [VAL_W:0]       acc_sum;
  logic [VAL_W-1:0]     acc_d, acc_q;
  logic                 pipe_busy;
  logic                 issue_last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign top_left_o  = top_left_q;

  // ---------------- RAM ----------------
  assign rd_a_addr = (state_q == ST_ISSUE) ? {cur_bank_q, i_q, k_q}
                                           : {cur_bank_q, IDX_FIRST, IDX_FIRST};
  assign rd_b_addr = {cur_bank_q, k_q, j_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mat_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mat_mem[rd_a_addr];
    rd_b_q <= mat_mem[rd_b_addr];
  end

  // ---------------- MAC pipeline ----------------
  assign tag0       = '{vld: (state_q == ST_ISSUE), i: i_q, j: j_q, k: k_q};
  assign issue_last = (i_q == IDX_LAST) && (j_q == IDX_LAST) && (k_q == IDX_LAST);
  assign pipe_busy  = tag1_q.vld | tag2_q.vld | tag3_q.vld | tag4_q.vld | tag5_q.vld;

  // Substitute the base matrix while the RAM holds nothing yet, and as the right operand of a multiply by the base.
  assign op_a   = base_q ? base_entry(tag1_q.i, tag1_q.k) : rd_a_q;
  assign op_b   = (base_q || mul_base_q) ? base_entry(tag1_q.k, tag1_q.j) : rd_b_q;
  assign prod_d = op_a * op_b;

  // Barrett quotient estimate, then remainder below three times the modulus.
  assign q2_d     = prod_q[PROD_W-1:VAL_W-1] * MU;
  assign q3m_full = q2_q[2*MU_W-1:MU_W] * MODULUS;
  assign rem_raw  = p3_q - q3m_q;

  always_comb begin
    if (rem_raw >= MODULUS_X2) begin
      res_d = VAL_W'(rem_raw - MODULUS_X2);
    end else if (rem_raw >= MODULUS_X1) begin
      res_d = VAL_W'(rem_raw - MODULUS_X1);
    end else begin
      res_d = VAL_W'(rem_raw);
    end
  end

  assign acc_sum = {1'b0, (tag5_q.k == IDX_FIRST) ? {VAL_W{1'b0}} : acc_q} + {1'b0, res_q};
  assign acc_d   = (acc_sum >= {1'b0, MODULUS}) ? VAL_W'(acc_sum - {1'b0, MODULUS})
                                                : acc_sum[VAL_W-1:0];

  // Write the finished entry into the other bank; a pass drains fully
  // before the banks swap, so reads never overlap these writes.
  assign wr_en   = tag5_q.vld && (tag5_q.k == IDX_LAST);
  assign wr_addr = {~cur_bank_q, tag5_q.i, tag5_q.j};
  assign wr_data = acc_d;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    q2_q   <= q2_d;
    p2_q   <= prod_q[RES_W-1:0];
    q3m_q  <= q3m_full[RES_W-1:0];
    p3_q   <= p2_q;
    res_q  <= res_d;
    if (tag5_q.vld) begin
      acc_q <= acc_d;
    end
  end

  // ---------------- Control ----------------
  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    bits_left_d = bits_left_q;
    started_d   = started_q;
    cur_bit_d   = cur_bit_q;
    mul_base_d  = mul_base_q;
    base_d      = base_q;
    cur_bank_d  = cur_bank_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    top_left_d  = top_left_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          exp_d       = exponent_i;
          bits_left_d = CNT_W'(EXP_BITS);
          started_d   = 1'b0;
          base_d      = 1'b1;
          cur_bank_d  = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (bits_left_q == '0) begin
          state_d = ST_READ;
        end else begin
          exp_d       = exp_q << 1;
          bits_left_d = bits_left_q - CNT_W'(1);
          if (!started_q) begin
            // Leading zeros are skipped; the top set bit stands for the base.
            started_d = exp_q[EXP_BITS-1];
          end else begin
            cur_bit_d  = exp_q[EXP_BITS-1];
            mul_base_d = 1'b0;
            i_d        = IDX_FIRST;
            j_d        = IDX_FIRST;
            k_d        = IDX_FIRST;
            state_d    = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (k_q != IDX_LAST) begin
          k_d = k_q + 2'd1;
        end else begin
          k_d = IDX_FIRST;
          if (j_q != IDX_LAST) begin
            j_d = j_q + 2'd1;
          end else begin
            j_d = IDX_FIRST;
            i_d = (i_q != IDX_LAST) ? i_q + 2'd1 : IDX_FIRST;
          end
        end
        if (issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          cur_bank_d = ~cur_bank_q;
          base_d     = 1'b0;
          if (!mul_base_q && cur_bit_q) begin
            mul_base_d = 1'b1;
            state_d    = ST_ISSUE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_READ: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          top_left_d  = base_q ? VAL_W'(1) : rd_a_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bits_left_q <= '0;
      started_q   <= 1'b0;
      cur_bit_q   <= 1'b0;
      mul_base_q  <= 1'b0;
      base_q      <= 1'b1;
      cur_bank_q  <= 1'b0;
      i_q         <= IDX_FIRST;
      j_q         <= IDX_FIRST;
      k_q         <= IDX_FIRST;
      out_valid_q <= 1'b0;
      tag1_q      <= '0;
      tag2_q      <= '0;
      tag3_q      <= '0;
      tag4_q      <= '0;
      tag5_q      <= '0;
    end else begin
      state_q     <= state_d;
      bits_left_q <= bits_left_d;
      started_q   <= started_d;
      cur_bit_q   <= cur_bit_d;
      mul_base_q  <= mul_base_d;
      base_q      <= base_d;
      cur_bank_q  <= cur_bank_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      tag1_q      <= tag0;
      tag2_q      <= tag1_q;
      tag3_q      <= tag2_q;
      tag4_q      <= tag3_q;
      tag5_q      <= tag4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q      <= exp_d;
    top_left_q <= top_left_d;
  end

  // ---------------- Assertions ----------------
  a_write_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
    else $error("matrix RAM written outside a pass");

  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_SCAN || state_q == ST_READ) |-> !pipe_busy)
    else $error("MAC pipeline busy after drain");

  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag5_q.vld |-> (res_q < MODULUS))
    else $error("Barrett remainder not reduced");

  a_out_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (top_left_o < MODULUS))
    else $error("result out of range");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SCAN && base_q))
    else $error("accepted transaction did not start a scan");

endmodule

`default_nettype wire
